// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the block clock, quiet while in reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the block clock, quiet while in reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gfba_pkg.sv -----
// ----------------------------------------------------------------------------
// gfba_pkg
// Types, constants and codes shared by the grouped free-block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

    localparam int GROUP_SIZE_DEF = 50;
    localparam int NUM_BLOCKS_DEF = 1024;

    localparam int BLK_W = 10;
    localparam int ENT_W = 11;

    localparam logic [ENT_W-1:0] NULL_MARK = 11'h7FF;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] free_block;
    } t_request;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        logic [1:0]       status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_SP_RD,
        S_SP_WR,
        S_SP_END,
        S_RL_CNT,
        S_RL_RD,
        S_RL_WR
    } t_state;

    typedef struct packed {
        logic latch;
        logic pop_rd;
        logic pop_done;
        logic push;
        logic res_full;
        logic res_freed;
        logic sp_rd;
        logic sp_wr;
        logic sp_end;
        logic rl_start;
        logic rl_empty;
        logic rl_rd;
        logic rl_wr;
    } t_cmd;

    typedef struct packed {
        logic req_free;
        logic blk_ok;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic base_null;
        logic sp_last;
        logic rl_n_zero;
        logic rl_last;
    } t_sts;

endpackage

// ----- rtl/grouped_free_block_allocator.sv -----
// Free, full and push requests: registered result in the cycle after accept, busy stays low.
// Pop from the stack: the stack read is registered, then S_POP loads the result register.
// Group spill on free to a full stack: one S_SP_RD/S_SP_WR pair per entry, then S_SP_END.
// Reload at link block: result in S_RL_CNT, then n S_RL_RD/S_RL_WR pairs, n = min(count, GS).
// Results cannot be stalled. Synchronous reset leaves one null entry on the stack;
// no clearing pass runs, the list and count memories are undefined until written.
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Disk-block allocator over a grouped free-block list with a controller and
// a memory datapath.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator #(
    parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
    parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gfba_pkg::t_request i_req,
    output gfba_pkg::t_result  o_res,
    output logic              o_strobe
);
    import gfba_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    gfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    gfba_dp #(
        .GROUP_SIZE (GROUP_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

endmodule

// ----- rtl/gfba_ctrl.sv -----
// ----------------------------------------------------------------------------
// gfba_ctrl
// Sequencer for the allocator: picks pop, push, spill, reload or a plain
// full/freed result per request; steps the datapath through group copies.
// ----------------------------------------------------------------------------
module gfba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gfba_pkg::t_sts i_sts,
    output gfba_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import gfba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_sts.req_free) begin
                        if (i_sts.blk_ok && i_sts.cnt_full) begin
                            n_state = S_SP_RD;
                        end
                    end else if (i_sts.cnt_zero || (i_sts.cnt_one && i_sts.base_null)) begin
                        n_state = S_IDLE;
                    end else if (i_sts.cnt_one) begin
                        n_state = S_RL_CNT;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP:    n_state = S_IDLE;
            S_SP_RD:  n_state = S_SP_WR;
            S_SP_WR:  n_state = i_sts.sp_last ? S_SP_END : S_SP_RD;
            S_SP_END: n_state = S_IDLE;
            S_RL_CNT: n_state = i_sts.rl_n_zero ? S_IDLE : S_RL_RD;
            S_RL_RD:  n_state = S_RL_WR;
            S_RL_WR:  n_state = i_sts.rl_last ? S_IDLE : S_RL_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    if (i_sts.req_free) begin
                        if (!i_sts.blk_ok) begin
                            o_cmd.res_freed = 1'b1;
                        end else if (!i_sts.cnt_full) begin
                            o_cmd.push      = 1'b1;
                            o_cmd.res_freed = 1'b1;
                        end
                    end else if (i_sts.cnt_zero || (i_sts.cnt_one && i_sts.base_null)) begin
                        o_cmd.res_full = 1'b1;
                    end else if (!i_sts.cnt_one) begin
                        o_cmd.pop_rd = 1'b1;
                    end
                end
            end
            S_POP:    o_cmd.pop_done = 1'b1;
            S_SP_RD:  o_cmd.sp_rd = 1'b1;
            S_SP_WR:  o_cmd.sp_wr = 1'b1;
            S_SP_END: begin
                o_cmd.sp_end    = 1'b1;
                o_cmd.res_freed = 1'b1;
            end
            S_RL_CNT: begin
                o_cmd.rl_start = 1'b1;
                o_cmd.rl_empty = i_sts.rl_n_zero;
            end
            S_RL_RD:  o_cmd.rl_rd = 1'b1;
            S_RL_WR:  o_cmd.rl_wr = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/gfba_dp.sv -----
// ----------------------------------------------------------------------------
// gfba_dp
// Allocator datapath: free stack, group list and group count memories,
// stack pointer, link register and the result register.
// ----------------------------------------------------------------------------
module gfba_dp #(
    parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
    parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gfba_pkg::t_request i_req,
    input  gfba_pkg::t_cmd     i_cmd,
    output gfba_pkg::t_sts     o_sts,
    output gfba_pkg::t_result  o_res,
    output logic              o_strobe
);
    import gfba_pkg::*;

    localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam int IDX_W  = $clog2(GROUP_SIZE);
    localparam int BA_W   = $clog2(NUM_BLOCKS);
    localparam int LDEPTH = NUM_BLOCKS * GROUP_SIZE;
    localparam int LA_W   = $clog2(LDEPTH);

    localparam logic [CNT_W-1:0] GS      = CNT_W'(GROUP_SIZE);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [ENT_W-1:0] NB      = ENT_W'(NUM_BLOCKS);
    localparam logic [LA_W-1:0]  GS_L    = LA_W'(GROUP_SIZE);

    // entry 0 of the stack lives in r_base; the array holds entries above it
    logic [ENT_W-1:0] r_stk  [GROUP_SIZE];
    logic [ENT_W-1:0] r_lst  [LDEPTH];
    logic [CNT_W-1:0] r_gcnt [NUM_BLOCKS];

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ENT_W-1:0] r_base, n_base;
    logic             r_strobe, n_strobe;
    logic [ENT_W-1:0] r_blk;
    logic [LA_W-1:0]  r_lbase;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_n;
    logic [ENT_W-1:0] r_stk_q;
    logic [ENT_W-1:0] r_lst_q;
    logic [CNT_W-1:0] r_cq;
    t_result          r_res, n_res;

    logic [ENT_W-1:0] w_blk;
    logic [ENT_W-1:0] w_mul_src;
    logic [CNT_W-1:0] w_top;
    logic [CNT_W-1:0] w_sp_src;
    logic [CNT_W-1:0] w_rl_dst;
    logic [CNT_W-1:0] w_nclamp;
    logic [IDX_W-1:0] w_stk_raddr;
    logic [LA_W-1:0]  w_laddr;
    logic             w_sp_last;
    logic [ENT_W-1:0] w_sp_data;

    assign w_blk       = ENT_W'(i_req.free_block);
    assign w_mul_src   = (i_req.mode == MODE_FREE) ? w_blk : r_base;
    assign w_top       = r_cnt - CNT_ONE;
    assign w_sp_src    = GS - CNT_ONE - r_idx;
    assign w_rl_dst    = r_n - CNT_ONE - r_idx;
    assign w_nclamp    = (r_cq > GS) ? GS : r_cq;
    assign w_stk_raddr = i_cmd.pop_rd ? w_top[IDX_W-1:0] : w_sp_src[IDX_W-1:0];
    assign w_laddr     = r_lbase + LA_W'(r_idx);
    assign w_sp_last   = (r_idx == GS - CNT_ONE);
    // bottom entry comes from the link register, not the array
    assign w_sp_data   = w_sp_last ? r_base : r_stk_q;

    always_comb begin
        o_sts.req_free  = (i_req.mode == MODE_FREE);
        o_sts.blk_ok    = (w_blk < NB);
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.cnt_one   = (r_cnt == CNT_ONE);
        o_sts.cnt_full  = (r_cnt >= GS);
        o_sts.base_null = (r_base == NULL_MARK);
        o_sts.sp_last   = w_sp_last;
        o_sts.rl_n_zero = (w_nclamp == '0);
        o_sts.rl_last   = (r_idx == r_n - CNT_ONE);
    end

    // free stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_cnt != '0)) begin
            r_stk[r_cnt[IDX_W-1:0]] <= w_blk;
        end else if (i_cmd.rl_wr && (w_rl_dst != '0)) begin
            r_stk[w_rl_dst[IDX_W-1:0]] <= r_lst_q;
        end
        if (i_cmd.pop_rd || i_cmd.sp_rd) begin
            r_stk_q <= r_stk[w_stk_raddr];
        end
    end

    // group lists
    always_ff @(posedge i_clk) begin
        if (i_cmd.sp_wr) begin
            r_lst[w_laddr] <= w_sp_data;
        end
        if (i_cmd.rl_rd) begin
            r_lst_q <= r_lst[w_laddr];
        end
    end

    // group counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.sp_end) begin
            r_gcnt[r_blk[BA_W-1:0]] <= GS;
        end
        if (i_cmd.latch) begin
            r_cq <= r_gcnt[r_base[BA_W-1:0]];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_blk   <= w_blk;
            r_lbase <= LA_W'(w_mul_src[BA_W-1:0]) * GS_L;
            r_idx   <= '0;
        end else if (i_cmd.rl_start) begin
            r_idx <= '0;
            r_n   <= w_nclamp;
        end else if (i_cmd.sp_wr || i_cmd.rl_wr) begin
            r_idx <= r_idx + CNT_ONE;
        end
        r_res <= n_res;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.pop_done) begin
            n_cnt = w_top;
        end else if (i_cmd.push) begin
            n_cnt = r_cnt + CNT_ONE;
        end else if (i_cmd.sp_end) begin
            n_cnt = CNT_ONE;
        end else if (i_cmd.rl_empty) begin
            n_cnt = '0;
        end else if (i_cmd.rl_wr && o_sts.rl_last) begin
            n_cnt = r_n;
        end
    end

    always_comb begin
        n_base = r_base;
        if (i_cmd.push && (r_cnt == '0)) begin
            n_base = w_blk;
        end else if (i_cmd.sp_end) begin
            n_base = r_blk;
        end else if (i_cmd.rl_empty) begin
            n_base = NULL_MARK;
        end else if (i_cmd.rl_wr && (w_rl_dst == '0)) begin
            n_base = r_lst_q;
        end
    end

    always_comb begin
        n_strobe = i_cmd.pop_done | i_cmd.rl_start | i_cmd.res_full | i_cmd.res_freed;
        n_res    = r_res;
        if (i_cmd.pop_done) begin
            n_res.granted_block = r_stk_q[BLK_W-1:0];
            n_res.status        = ST_ALLOC;
        end else if (i_cmd.rl_start) begin
            n_res.granted_block = r_base[BLK_W-1:0];
            n_res.status        = ST_ALLOC;
        end else if (i_cmd.res_full) begin
            n_res.granted_block = '0;
            n_res.status        = ST_FULL;
        end else if (i_cmd.res_freed) begin
            n_res.granted_block = '0;
            n_res.status        = ST_FREED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CNT_ONE;
            r_base   <= NULL_MARK;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_base   <= n_base;
            r_strobe <= n_strobe;
        end
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

// ----- rtl/gfba_checker.sv -----
// ----------------------------------------------------------------------------
// gfba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input gfba_pkg::t_result o_res,
    input logic              o_strobe
);
    import gfba_pkg::*;

    `ASSERT_IMP(a_status_code, o_strobe, (o_res.status == ST_ALLOC) || (o_res.status == ST_FULL) || (o_res.status == ST_FREED), "unknown result status")
    `ASSERT_IMP(a_zero_grant, o_strobe && (o_res.status != ST_ALLOC), o_res.granted_block == '0, "grant on non-allocate result")
    `ASSERT_NXT(a_accept_follow, start && !busy, o_strobe || busy, "accepted beat left no trace")
    `ASSERT_IMP(a_no_spurious, o_strobe, $past(start && !busy) || $past(busy), "result without work")

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);

// ----- sim/grouped_free_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_tb
// Drives allocate and free beats into the grouped free-block allocator and
// compares every result with a fixed directed value or a local model of the
// free stack and the per-block link lists. A short directed table comes first,
// then random phases biased toward frees or allocates so that group spills,
// link reloads and the disk-full case are all reached.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_tb;
    import gfba_pkg::*;

    localparam int GRP        = GROUP_SIZE_DEF;
    localparam int NBLK       = NUM_BLOCKS_DEF;
    localparam int RAND_ITEMS = 1250;
    localparam int TAIL_WAIT  = 2 * GRP + 20;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DIR_ROWS   = 20;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] blk;
        logic             fixed;
        t_result          res;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_req;
    t_result  o_res;
    logic     o_strobe;

    grouped_free_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_strobe(o_strobe)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Local copy of the allocator state
    logic [ENT_W-1:0] pool_stack [GRP];
    int               pool_depth;
    logic [ENT_W-1:0] link_lists [NBLK][GRP];
    int               link_counts [NBLK];

    t_result pending_results [$];
    int      err_cnt;
    int      cycle_cnt;
    logic    took;
    logic    cur_fixed;
    t_result cur_res;
    t_result want;
    t_result got_pred;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{MODE_ALLOC, 10'd1023, 1'b1, '{10'd0,    ST_FULL}},
        '{MODE_FREE,  10'd0,    1'b1, '{10'd0,    ST_FREED}},
        '{MODE_FREE,  10'd1023, 1'b1, '{10'd0,    ST_FREED}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd1023, ST_ALLOC}},
        '{MODE_ALLOC, 10'd1023, 1'b1, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd0,    ST_FULL}},
        '{MODE_FREE,  10'd341,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_FREE,  10'd682,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_FREE,  10'd341,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd682,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd341,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd0,    ST_FULL}},
        '{MODE_FREE,  10'd512,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_FREE,  10'd511,  1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_FREE,  10'd1,    1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b0, '{10'd0,    ST_ALLOC}},
        '{MODE_ALLOC, 10'd0,    1'b1, '{10'd0,    ST_FULL}}
    };

    task automatic report_mismatch(input string what, input logic [BLK_W-1:0] got,
                                   input logic [BLK_W-1:0] exp_val);
        $display("ERROR cycle %0d: %s got %0d, expected %0d", cycle_cnt, what, got, exp_val);
        err_cnt++;
    endtask

    // Apply one allocate or free to the local state and return its result
    function automatic t_result alloc_step(input t_request rq);
        t_result          r;
        logic [ENT_W-1:0] link;
        int               n;
        int               top;
        r.granted_block = '0;
        if (rq.mode == MODE_ALLOC) begin
            if (pool_depth == 0 || (pool_depth == 1 && pool_stack[0] == NULL_MARK)) begin
                r.status = ST_FULL;
            end else if (pool_depth == 1) begin
                // Grant the link block and reload the stack from its list
                link = pool_stack[0];
                r.granted_block = link[BLK_W-1:0];
                n = 0;
                if (int'(link) < NBLK) begin
                    n = link_counts[link] & 63;
                    if (n > GRP)
                        n = GRP;
                    for (int i = 0; i < n; i++)
                        pool_stack[n-1-i] = link_lists[link][i];
                end
                if (n == 0)
                    pool_stack[0] = NULL_MARK;
                pool_depth = n;
                r.status = ST_ALLOC;
            end else begin
                top = pool_depth - 1;
                if (top >= GRP)
                    top = GRP - 1;
                r.granted_block = pool_stack[top][BLK_W-1:0];
                pool_stack[top] = NULL_MARK;
                pool_depth = top;
                r.status = ST_ALLOC;
            end
        end else begin
            r.status = ST_FREED;
            if (int'(rq.free_block) < NBLK) begin
                if (pool_depth >= GRP) begin
                    // Spill the full stack into the freed block's list
                    for (int i = 0; i < GRP; i++) begin
                        link_lists[rq.free_block][i] = pool_stack[GRP-1-i];
                        pool_stack[GRP-1-i] = NULL_MARK;
                    end
                    link_counts[rq.free_block] = GRP;
                    pool_stack[0] = {1'b0, rq.free_block};
                    pool_depth = 1;
                end else begin
                    pool_stack[pool_depth] = {1'b0, rq.free_block};
                    pool_depth++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("grouped_free_block_allocator_tb NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, granted_block", o_res.granted_block,
                                    '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.granted_block !== want.granted_block)
                        report_mismatch("granted_block", o_res.granted_block,
                                        want.granted_block);
                    if (o_res.status !== want.status)
                        report_mismatch("status", BLK_W'(o_res.status), BLK_W'(want.status));
                end
            end
            if (start && busy === 1'b0) begin
                got_pred = alloc_step(i_req);
                pending_results.push_back(cur_fixed ? cur_res : got_pred);
                took = 1'b1;
            end
        end
    end

    // Hold start high across back-to-back beats; drop it only before a gap
    task automatic send_beat(input logic mode, input logic [BLK_W-1:0] blk, input int gap,
                             input logic fixed, input t_result res);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req.mode       = mode;
        i_req.free_block = blk;
        cur_fixed        = fixed;
        cur_res          = res;
        took             = 1'b0;
        start            = 1'b1;
        @(negedge i_clk);
        while (!took)
            @(negedge i_clk);
    endtask

    // Drop start so the last beat is not taken again, then wait for the results
    task automatic drain_results();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int      sent;
        int      seg_len;
        int      free_pct;
        int      seg_idx;
        logic    no_gaps;
        logic    mode;
        t_result blank;
        err_cnt    = 0;
        cycle_cnt  = 0;
        took       = 1'b0;
        cur_fixed  = 1'b0;
        cur_res    = '0;
        blank      = '0;
        start      = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        for (int i = 0; i < GRP; i++)
            pool_stack[i] = NULL_MARK;
        pool_depth = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i])
            send_beat(dir_tab[i].mode, dir_tab[i].blk, $urandom_range(0, 3),
                      dir_tab[i].fixed, dir_tab[i].res);
        // Let the sender sit until every result is back
        drain_results();

        sent    = 0;
        seg_idx = 0;
        while (sent < RAND_ITEMS) begin
            // Fill well past a few spills first, then drain through the reloads
            case (seg_idx)
                0: begin
                    seg_len  = 170;
                    free_pct = 95;
                end
                1: begin
                    seg_len  = 220;
                    free_pct = 5;
                end
                default: begin
                    seg_len  = $urandom_range(40, 160);
                    case ($urandom_range(0, 4))
                        0: free_pct = 95;
                        1: free_pct = 80;
                        2: free_pct = 50;
                        3: free_pct = 20;
                        default: free_pct = 5;
                    endcase
                end
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RAND_ITEMS; k++) begin
                mode = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
                send_beat(mode, BLK_W'($urandom_range(0, NBLK - 1)),
                          no_gaps ? 0 : $urandom_range(0, 19), 1'b0, blank);
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                drain_results();
            seg_idx++;
        end
        start = 1'b0;

        drain_results();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("grouped_free_block_allocator_tb OK");
        end else begin
            $display("grouped_free_block_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
